// ===== src/fau_pkg.sv =====
// Shared types, widths and opcodes for the feature accumulator update block.
package fau_pkg;

    localparam int ELEM_W    = 16;
    localparam int LANES     = 16;
    localparam int LANE_BITS = 4;
    localparam int COL_W     = 8;
    localparam int FEAT_W    = 7;
    localparam int OP_W      = 3;

    localparam int DEF_ACC_WIDTH    = 256;
    localparam int DEF_NUM_FEATURES = 128;

    localparam logic [OP_W-1:0] OP_LOAD_WEIGHT    = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_FEATURE    = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_FEATURE = 3'd2;
    localparam logic [OP_W-1:0] OP_READ_ACC       = 3'd3;
    localparam logic [OP_W-1:0] OP_WRITE_ACC      = 3'd4;

    typedef logic [ELEM_W-1:0] elem_t;
    typedef elem_t [LANES-1:0] chunk_t;

    // Control for the lane unit that sits in the chain's feedback path
    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic                 hit;
        logic [LANE_BITS-1:0] lane;
        elem_t                data;
    } upd_ctrl_t;

endpackage

// ===== src/fau_cell.sv =====
// One accumulator cell: holds a chunk of lanes and takes its neighbor's chunk on shift.
module fau_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  fau_pkg::chunk_t din,
    output fau_pkg::chunk_t dout
);
    import fau_pkg::*;

    chunk_t chunk_reg;

    // Hold the chunk, advance it when the chain rotates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg <= '0;
        end
        else if (shift)
        begin
            chunk_reg <= din;
        end
    end

    assign dout = chunk_reg;

endmodule

// ===== src/fau_update.sv =====
// Lane unit: adds, subtracts or patches the chunk leaving the head of the chain.
module fau_update (
    input  fau_pkg::upd_ctrl_t ctrl,
    input  fau_pkg::chunk_t    acc,
    input  fau_pkg::chunk_t    wgt,
    output fau_pkg::chunk_t    result
);
    import fau_pkg::*;

    // Work all lanes side by side, wrapping modulo 2^16
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            case (ctrl.op)
                OP_ADD_FEATURE:    result[i] = acc[i] + wgt[i];
                OP_REMOVE_FEATURE: result[i] = acc[i] - wgt[i];
                OP_WRITE_ACC:
                    result[i] = (ctrl.hit && (ctrl.lane == LANE_BITS'(i))) ? ctrl.data
                                                                           : acc[i];
                default:           result[i] = acc[i];
            endcase
        end
    end

endmodule

// ===== src/fau_weight_mem.sv =====
// Weight memory: one chunk per row, per-lane write, registered chunk read.
module fau_weight_mem #(
    parameter int ADDR_W = 11
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [ADDR_W-1:0]             waddr,
    input  logic [fau_pkg::LANE_BITS-1:0] wlane,
    input  fau_pkg::elem_t                wdata,
    input  logic [ADDR_W-1:0]             raddr,
    output fau_pkg::chunk_t               rdata
);
    import fau_pkg::*;

    chunk_t mem [2**ADDR_W];
    chunk_t rdata_reg;

    // Write one lane, read one whole row
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr][wlane] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/feature_accumulator_update.sv =====
// Top level: accumulator chain of cells, weight memory and item sequencer.
// Load weight, a spare opcode, an add or remove naming an out-of-range row, or a write naming an
// out-of-range column leaves the sequencer idle. Add, remove, read and write take the transfer,
// then NCHUNK steps that each rotate one 16-lane chunk through the lane unit.
// rsp_valid rises once a read's last step ends; a read waits while the last result stalls.
// Reset clears the accumulator to zero; the weight memory is not cleared.
module feature_accumulator_update #(
    parameter int ACC_WIDTH    = fau_pkg::DEF_ACC_WIDTH,
    parameter int NUM_FEATURES = fau_pkg::DEF_NUM_FEATURES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_stall,
    input  logic [fau_pkg::OP_W-1:0]    opcode,
    input  logic [fau_pkg::FEAT_W-1:0]  feature_index,
    input  logic [fau_pkg::COL_W-1:0]   column,
    input  logic signed [fau_pkg::ELEM_W-1:0] data_value,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output logic [fau_pkg::COL_W-1:0]   read_column,
    output logic signed [fau_pkg::ELEM_W-1:0] read_value
);
    import fau_pkg::*;

    localparam int NCHUNK = (ACC_WIDTH + LANES - 1) / LANES;
    localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int FW     = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam int AW     = FW + CW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_HOLD
    } state_t;

    state_t               state_reg;
    logic [OP_W-1:0]      op_reg;
    logic [FW-1:0]        feat_reg;
    logic [CW-1:0]        chunk_reg;
    logic [CW-1:0]        count_reg;
    logic [LANE_BITS-1:0] lane_reg;
    elem_t                data_reg;
    logic [COL_W-1:0]     col_reg;
    logic                 col_ok_reg;
    elem_t                cap_reg;
    logic                 rsp_valid_reg;
    logic [COL_W-1:0]     read_column_reg;
    elem_t                read_value_reg;

    logic                 cmd_xfer;
    logic                 rsp_xfer;
    logic                 slot_free;
    logic                 rsp_load;
    logic                 rsp_valid_next;
    logic                 feat_ok;
    logic                 col_ok;
    logic [FW-1:0]        feat_addr;
    logic [CW-1:0]        col_chunk;
    logic                 last_step;
    logic                 hit;
    elem_t                cap_next;
    logic                 shift;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [AW-1:0]        mem_raddr;
    chunk_t               wgt_row;
    chunk_t               feedback;
    chunk_t               cell_q [NCHUNK];
    upd_ctrl_t            upd_ctrl;

    // Decode the incoming transfer
    assign cmd_stall = (state_reg != ST_IDLE);
    assign cmd_xfer  = cmd_valid && !cmd_stall;
    assign rsp_xfer  = rsp_valid_reg && !rsp_stall;
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign feat_ok   = 32'(feature_index) < NUM_FEATURES;
    assign col_ok    = 32'(column) < ACC_WIDTH;
    assign feat_addr = FW'(feature_index);
    assign col_chunk = CW'(column >> LANE_BITS);

    // Load the result register at the end of a read, clear it when its transfer leaves
    assign rsp_load       = slot_free &&
                            ((state_reg == ST_HOLD) ||
                             ((state_reg == ST_ROTATE) && last_step && (op_reg == OP_READ_ACC)));
    assign rsp_valid_next = rsp_load || (rsp_valid_reg && !rsp_xfer);

    // Track which chunk sits at the head of the chain
    assign last_step = (count_reg == CW'(NCHUNK - 1));
    assign hit       = col_ok_reg && (count_reg == chunk_reg);
    assign cap_next  = hit ? cell_q[0][lane_reg] : cap_reg;
    assign shift     = (state_reg == ST_ROTATE);

    // Address the weight memory: first row at the transfer, then one ahead of the chain
    assign mem_we    = cmd_xfer && (opcode == OP_LOAD_WEIGHT) && feat_ok && col_ok;
    assign mem_waddr = {feat_addr, col_chunk};
    assign mem_raddr = (state_reg == ST_IDLE) ? {feat_addr, {CW{1'b0}}}
                                              : {feat_reg, count_reg + CW'(1)};

    fau_weight_mem #(
        .ADDR_W (AW)
    ) u_weight_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wlane (column[LANE_BITS-1:0]),
        .wdata (elem_t'(data_value)),
        .raddr (mem_raddr),
        .rdata (wgt_row)
    );

    assign upd_ctrl.op   = op_reg;
    assign upd_ctrl.hit  = hit;
    assign upd_ctrl.lane = lane_reg;
    assign upd_ctrl.data = data_reg;

    fau_update u_update (
        .ctrl   (upd_ctrl),
        .acc    (cell_q[0]),
        .wgt    (wgt_row),
        .result (feedback)
    );

    // Chain the cells: each takes from the next, the tail takes the lane unit's result
    for (genvar g = 0; g < NCHUNK; g++)
    begin : g_cell
        if (g == NCHUNK - 1)
        begin : g_tail
            fau_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .din   (feedback),
                .dout  (cell_q[g])
            );
        end
        else
        begin : g_body
            fau_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .din   (cell_q[g+1]),
                .dout  (cell_q[g])
            );
        end
    end

    // Sequence items and hold the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            op_reg          <= OP_LOAD_WEIGHT;
            count_reg       <= '0;
            col_ok_reg      <= 1'b0;
            cap_reg         <= '0;
            rsp_valid_reg   <= 1'b0;
            feat_reg        <= '0;
            chunk_reg       <= '0;
            lane_reg        <= '0;
            data_reg        <= '0;
            col_reg         <= '0;
            read_column_reg <= '0;
            read_value_reg  <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_xfer)
                    begin
                        op_reg     <= opcode;
                        feat_reg   <= feat_addr;
                        chunk_reg  <= col_chunk;
                        lane_reg   <= column[LANE_BITS-1:0];
                        data_reg   <= elem_t'(data_value);
                        col_reg    <= column;
                        col_ok_reg <= col_ok;
                        cap_reg    <= '0;
                        count_reg  <= '0;
                        if ((opcode inside {OP_ADD_FEATURE, OP_REMOVE_FEATURE}) && feat_ok)
                        begin
                            state_reg <= ST_ROTATE;
                        end
                        else if ((opcode == OP_READ_ACC) ||
                                 ((opcode == OP_WRITE_ACC) && col_ok))
                        begin
                            state_reg <= ST_ROTATE;
                        end
                    end
                end
                ST_ROTATE:
                begin
                    count_reg <= count_reg + CW'(1);
                    cap_reg   <= cap_next;
                    if (last_step)
                    begin
                        if (op_reg == OP_READ_ACC)
                        begin
                            if (slot_free)
                            begin
                                read_column_reg <= col_reg;
                                read_value_reg  <= cap_next;
                                state_reg       <= ST_IDLE;
                            end
                            else
                            begin
                                state_reg <= ST_HOLD;
                            end
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_HOLD:
                begin
                    if (slot_free)
                    begin
                        read_column_reg <= col_reg;
                        read_value_reg  <= cap_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign read_column = read_column_reg;
    assign read_value  = read_value_reg;

endmodule

// ===== src/fau_checker.sv =====
// Port-level checks for the feature accumulator update block, bound to the top level.
module fau_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cmd_valid,
    input logic                        cmd_stall,
    input logic [fau_pkg::OP_W-1:0]    opcode,
    input logic                        rsp_valid,
    input logic                        rsp_stall,
    input logic [fau_pkg::COL_W-1:0]   read_column,
    input logic signed [fau_pkg::ELEM_W-1:0] read_value
);
    import fau_pkg::*;

    // A stalled result stays and holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(read_column) && $stable(read_value))
        else $error("stalled result dropped or changed");

    // A read always walks the chain, so the block is busy right after it
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && (opcode == OP_READ_ACC) |=> cmd_stall)
        else $error("read transfer did not start a rotation");

    // A weight load finishes in its own cycle
    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && (opcode == OP_LOAD_WEIGHT) |=> !cmd_stall)
        else $error("weight load kept the block busy");

    // A result only appears at the end of a busy stretch
    a_rsp_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(cmd_stall))
        else $error("result appeared without a read in progress");

endmodule

bind feature_accumulator_update fau_checker u_fau_checker (.*);
